FILE: sv/vcc_pkg.sv
// Package for the Vigenere charset cipher: sizes, item types, mode and status codes,
// the sequencer state type and the character normalising function.
// No dependencies; every other file imports it.
package vcc_pkg;

	localparam int ALPHABET_DEPTH = 64;
	localparam int KEY_DEPTH      = 64;

	localparam int ALPHA_AW   = $clog2(ALPHABET_DEPTH);
	localparam int KEY_AW     = $clog2(KEY_DEPTH);
	localparam int CNT_W      = $clog2(KEY_DEPTH + 1);
	localparam int SCAN_W     = ALPHA_AW + 1;
	localparam int ACC_W      = ALPHA_AW + 1;
	localparam int KIDX_W     = 6;
	localparam int CHAR_W     = 8;
	localparam int MODE_W     = 3;
	localparam int ENTRY_W    = 6;
	localparam int STATUS_W   = 2;
	localparam int SIZE_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_TEXT    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_KEY_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_KEY_FULL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION     = 1'd1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd27;

	localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A    = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z    = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET     = 8'h20;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [CHAR_W-1:0]  char_in;
		logic [ENTRY_W-1:0] entry_index;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]   char_out;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MOD,
		ST_COMBINE,
		ST_WRAP,
		ST_READ,
		ST_LOOKUP,
		ST_EMIT
	} state_t;

	// Upper-case ASCII letters fold to lower case and a space becomes an underscore.
	function automatic logic [CHAR_W-1:0] normalize_char(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end else if (c == CHAR_SPACE) begin
			r = CHAR_UNDERSCORE;
		end
		return r;
	endfunction

endpackage

FILE: sv/vigenere_charset_cipher.sv
// Top level of the Vigenere charset cipher: sequencer, key store, shared subtractor
// and result register. Depends on vcc_pkg and vcc_alpha_ram.
//
// Each accepted item either loads one alphabet entry, clears the key, appends a key
// character, restarts the key position or carries one text character. Loads, clears,
// restarts and unused modes are finished when taken and give no result. Key and text
// characters are matched against the alphabet one entry per cycle through the single
// read port of the alphabet memory, over the first n entries, where n is the active
// alphabet size (at most 64). A text character that matches then brings its key index
// below n by repeated subtraction (none when the key was built with the current size,
// up to 63 for a key left over from a larger alphabet), finds it below, adds or
// subtracts the key, wraps, reads the alphabet memory and hands the result to the
// output register. The input stall is high for as long as the block works on an item.
// A finished result sits in the output register until taken, and the block accepts
// the next item meanwhile; only a second result that finds the register still
// occupied waits for it. A text item with an empty key answers at once with status
// key-empty, and a key character that matches while the key store is full answers
// with status key-full; both carry a zero character. Configuration writes land
// immediately and should only be made while the block is idle. Alphabet entries that
// were never loaded read as unknown data.
module vigenere_charset_cipher (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  vcc_pkg::in_item_t                item,
	output logic                             res_valid,
	input  logic                             res_stall,
	output vcc_pkg::out_item_t               res,
	input  logic                             cfg_we,
	input  logic [vcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import vcc_pkg::*;

	// Sequencer state and configuration registers.
	state_t state_q, state_d;
	logic [SIZE_W-1:0] alpha_size_q;
	logic              direction_q;

	// Item being worked on.
	logic [MODE_W-1:0] mode_q;
	logic [CHAR_W-1:0] char_q;

	// Key store and its pointers.
	logic [KIDX_W-1:0] key_mem [KEY_DEPTH];
	logic [KIDX_W-1:0] key_rd_q;
	logic [CNT_W-1:0]  key_count_q;
	logic [KEY_AW-1:0] key_pos_q;

	// Search sequencer.
	logic [SCAN_W-1:0]   scan_q;
	logic                pend_q;
	logic [ALPHA_AW-1:0] pend_idx_q;
	logic [ALPHA_AW-1:0] slot_q;

	// Shared accumulator for modulo reduction and the final index.
	logic [ACC_W-1:0] acc_q;

	// Result waiting to be moved to the output register, and the output register.
	out_item_t res_pend_q;
	out_item_t res_q;
	logic      res_valid_q;

	// Combinational signals.
	logic                accept;
	logic [ACC_W-1:0]    n_act;
	logic [ACC_W:0]      sub_diff;
	logic                acc_ge_n;
	logic                scan_issue;
	logic                match;
	logic                miss;
	logic                key_full;
	logic                res_free;
	logic [ALPHA_AW-1:0] alpha_raddr;
	logic [CHAR_W-1:0]   alpha_rdata;
	logic [CNT_W-1:0]    pos_eff;
	logic [CNT_W-1:0]    pos_inc;
	logic [CHAR_W-1:0]   lookup_char;

	assign accept     = item_valid && (state_q == ST_IDLE);
	assign item_stall = (state_q != ST_IDLE);

	// Sizes beyond the physical alphabet saturate.
	assign n_act = (alpha_size_q > SIZE_W'(ALPHABET_DEPTH)) ? ACC_W'(ALPHABET_DEPTH)
	                                                        : ACC_W'(alpha_size_q);

	// The one subtract-and-compare unit, shared by reduction and wrap.
	assign sub_diff = {1'b0, acc_q} - {1'b0, n_act};
	assign acc_ge_n = !sub_diff[ACC_W];

	assign scan_issue = (state_q == ST_SEARCH) && (ACC_W'(scan_q) < n_act);
	assign match      = (state_q == ST_SEARCH) && pend_q && (alpha_rdata == char_q);
	assign miss       = (state_q == ST_SEARCH) && !pend_q && !scan_issue;
	assign key_full   = (key_count_q >= CNT_W'(KEY_DEPTH));
	assign res_free   = !res_valid_q || !res_stall;

	assign alpha_raddr = (state_q == ST_READ) ? acc_q[ALPHA_AW-1:0]
	                                          : scan_q[ALPHA_AW-1:0];

	// Position actually used by a text item, and where it moves to afterwards.
	assign pos_eff = ({1'b0, key_pos_q} >= key_count_q) ? '0 : CNT_W'(key_pos_q);
	assign pos_inc = pos_eff + CNT_W'(1);

	// Encrypt output is upper-cased.
	always_comb begin
		lookup_char = alpha_rdata;
		if (!direction_q && alpha_rdata >= CHAR_LOWER_A && alpha_rdata <= CHAR_LOWER_Z) begin
			lookup_char = alpha_rdata - CASE_OFFSET;
		end
	end

	vcc_alpha_ram u_alpha_ram (
		.clk   (clk),
		.we    (accept && (item.mode == MODE_LOAD)),
		.waddr (item.entry_index[ALPHA_AW-1:0]),
		.wdata (item.char_in),
		.raddr (alpha_raddr),
		.rdata (alpha_rdata)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (item.mode)
						MODE_APPEND: state_d = ST_SEARCH;
						MODE_TEXT:   state_d = (key_count_q == '0) ? ST_EMIT : ST_SEARCH;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (match) begin
					if (mode_q == MODE_APPEND) begin
						state_d = key_full ? ST_EMIT : ST_IDLE;
					end else begin
						state_d = ST_MOD;
					end
				end else if (miss) begin
					state_d = ST_IDLE;
				end
			end
			ST_MOD: begin
				if (!acc_ge_n) begin
					state_d = ST_COMBINE;
				end
			end
			ST_COMBINE: state_d = ST_WRAP;
			ST_WRAP:    state_d = ST_READ;
			ST_READ:    state_d = ST_LOOKUP;
			ST_LOOKUP:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_size_q <= SIZE_RESET;
			direction_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHABET_SIZE: alpha_size_q <= cfg_data[SIZE_W-1:0];
				REG_DIRECTION:     direction_q  <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	// Key count and position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			key_pos_q   <= '0;
		end else begin
			if (accept) begin
				case (item.mode)
					MODE_CLEAR: begin
						key_count_q <= '0;
						key_pos_q   <= '0;
					end
					MODE_RESTART: key_pos_q <= '0;
					MODE_TEXT: begin
						if (key_count_q != '0) begin
							key_pos_q <= (pos_inc >= key_count_q) ? '0
							                                      : pos_inc[KEY_AW-1:0];
						end
					end
					default: ;
				endcase
			end
			if (match && (mode_q == MODE_APPEND) && !key_full) begin
				key_count_q <= key_count_q + CNT_W'(1);
			end
		end
	end

	// Key store: written when a key character matches and the store is not full, read whenever an item is accepted.
	always_ff @(posedge clk) begin
		if (match && (mode_q == MODE_APPEND) && !key_full) begin
			key_mem[key_count_q[KEY_AW-1:0]] <= KIDX_W'(pend_idx_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_rd_q <= key_mem[pos_eff[KEY_AW-1:0]];
		end
	end

	// Search control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			pend_q <= 1'b0;
		end else if (state_q == ST_SEARCH) begin
			pend_q <= scan_issue && !match;
			if (scan_issue) begin
				scan_q <= scan_q + SCAN_W'(1);
			end
		end else begin
			scan_q <= '0;
			pend_q <= 1'b0;
		end
	end

	// Item payload, slot, accumulator and the pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= item.mode;
			char_q <= normalize_char(item.char_in);
			res_pend_q.char_out <= '0;
			res_pend_q.status   <= STATUS_KEY_EMPTY;
		end
		if (scan_issue) begin
			pend_idx_q <= scan_q[ALPHA_AW-1:0];
		end
		if (match) begin
			slot_q <= pend_idx_q;
			acc_q  <= ACC_W'(key_rd_q);
			res_pend_q.char_out <= '0;
			res_pend_q.status   <= STATUS_KEY_FULL;
		end
		case (state_q)
			ST_MOD: begin
				if (acc_ge_n) begin
					acc_q <= sub_diff[ACC_W-1:0];
				end
			end
			ST_COMBINE: begin
				if (direction_q) begin
					acc_q <= ACC_W'(slot_q) + n_act - acc_q;
				end else begin
					acc_q <= ACC_W'(slot_q) + acc_q;
				end
			end
			ST_WRAP: begin
				if (acc_ge_n) begin
					acc_q <= sub_diff[ACC_W-1:0];
				end
			end
			ST_LOOKUP: begin
				res_pend_q.char_out <= lookup_char;
				res_pend_q.status   <= STATUS_OK;
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && res_free) begin
			res_q <= res_pend_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The key count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= CNT_W'(KEY_DEPTH))
		else $error("key count beyond key store depth");

	// With a key present the position always points inside it; with none it rests at zero.
	a_pos_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(key_count_q == '0) ? (key_pos_q == '0) : ({1'b0, key_pos_q} < key_count_q))
		else $error("key position outside the key");

	// An error result always carries a zero character.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status != STATUS_OK)) |-> (res.char_out == '0))
		else $error("error result with nonzero character");

	// A new result only appears after the sequencer has handed one over.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the hand-over state");

	// The final alphabet index is reduced below the size before it is read.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (acc_q < n_act))
		else $error("final index not below the alphabet size");

endmodule

FILE: sv/vcc_alpha_ram.sv
// Alphabet store of the Vigenere charset cipher: one write port, one read port,
// read data registered. Depends on vcc_pkg.
module vcc_alpha_ram (
	input  logic                           clk,
	input  logic                           we,
	input  logic [vcc_pkg::ALPHA_AW-1:0]   waddr,
	input  logic [vcc_pkg::CHAR_W-1:0]     wdata,
	input  logic [vcc_pkg::ALPHA_AW-1:0]   raddr,
	output logic [vcc_pkg::CHAR_W-1:0]     rdata
);
	import vcc_pkg::*;

	logic [CHAR_W-1:0] mem [ALPHABET_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for vigenere_charset_cipher: a short directed run, then
// phases of random key and text sequences under several alphabet sizes and directions.
// Depends on vcc_pkg and the RTL of the block; it reads and writes no files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vcc_pkg::*;

	// The limit leaves ample margin over the slowest correct run.
	localparam int CYCLE_LIMIT = 1_500_000;
	// A text item that matches nothing keeps the block busy through its search without
	// producing anything, so the testbench lets the block settle before a write.
	localparam int SETTLE_CYCLES = 200;
	// Modes 5 to 7 are spare codes that the block must ignore.
	localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
	localparam int CHARSET_LEN = 37;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	in_item_t              item       = '0;
	logic                  res_valid;
	logic                  res_stall  = 1'b0;
	out_item_t             res;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	vigenere_charset_cipher u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow of the cipher state, advanced as each item is accepted by the block.
	logic [CHAR_W-1:0] alpha_shadow [ALPHABET_DEPTH];
	logic [KIDX_W-1:0] key_shadow [KEY_DEPTH];
	int unsigned       key_len     = 0;
	int unsigned       key_pos     = 0;
	logic [SIZE_W-1:0] size_shadow = SIZE_RESET;
	logic              dir_shadow  = 1'b0;

	// The alphabet as the stimulus generator will have left it once its items are
	// taken; it lets the generator choose characters that actually match.
	logic [CHAR_W-1:0] alpha_plan [ALPHABET_DEPTH];

	out_item_t   cipher_results [$];
	in_item_t    items_to_send [$];
	out_item_t   oldest_result;
	int unsigned items_queued = 0;
	int unsigned items_taken  = 0;
	int unsigned worked_items = 0;
	int unsigned fail_count   = 0;
	int unsigned cycle_count  = 0;
	int unsigned src_gap_left;
	int unsigned snk_stall_left;
	int          src_idle_pct = 10;
	int          snk_idle_pct = 10;

	// Number of alphabet slots searched: the size register saturates at the depth.
	function automatic int unsigned alphabet_span();
		return (size_shadow > ALPHABET_DEPTH) ? ALPHABET_DEPTH : int'(size_shadow);
	endfunction

	// Folds upper-case letters and a space, then finds the lowest matching slot.
	function automatic bit lookup_slot(input logic [CHAR_W-1:0] c, output int unsigned slot);
		logic [CHAR_W-1:0] folded;
		int unsigned       span;
		folded = c;
		span = alphabet_span();
		slot = 0;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			folded = c + CASE_OFFSET;
		end else if (c == CHAR_SPACE) begin
			folded = CHAR_UNDERSCORE;
		end
		for (int unsigned i = 0; i < span; i++) begin
			if (alpha_shadow[i] == folded) begin
				slot = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Applies one accepted item to the shadow state and queues the result it causes.
	function automatic void cipher_step(input in_item_t it);
		int unsigned       slot;
		int unsigned       span;
		int unsigned       shift;
		int unsigned       target;
		logic [CHAR_W-1:0] ch;
		case (it.mode)
		MODE_LOAD: begin
			alpha_shadow[it.entry_index] = it.char_in;
		end
		MODE_CLEAR: begin
			key_len = 0;
			key_pos = 0;
		end
		MODE_APPEND: begin
			if (lookup_slot(it.char_in, slot)) begin
				if (key_len >= KEY_DEPTH) begin
					cipher_results.push_back('{char_out: '0, status: STATUS_KEY_FULL});
				end else begin
					key_shadow[key_len] = slot[KIDX_W-1:0];
					key_len++;
				end
			end
		end
		MODE_TEXT: begin
			if (key_len == 0) begin
				// No key yet: the position stays put and the block reports it.
				cipher_results.push_back('{char_out: '0, status: STATUS_KEY_EMPTY});
			end else begin
				if (key_pos >= key_len) begin
					key_pos = 0;
				end
				shift = key_shadow[key_pos];
				key_pos++;
				if (key_pos >= key_len) begin
					key_pos = 0;
				end
				// The position moves on even when the character is then dropped.
				if (lookup_slot(it.char_in, slot)) begin
					span = alphabet_span();
					// A key index from a larger alphabet is reduced before use.
					shift = shift % span;
					if (dir_shadow == 1'b0) begin
						target = (slot + shift) % span;
					end else begin
						target = (slot + span - shift) % span;
					end
					ch = alpha_shadow[target];
					if (dir_shadow == 1'b0 && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
						ch = ch - CASE_OFFSET;
					end
					cipher_results.push_back('{char_out: ch, status: STATUS_OK});
				end
			end
		end
		MODE_RESTART: begin
			key_pos = 0;
		end
		default: begin
		end
		endcase
	endfunction

	// Driver: presents queued items, holding each one steady while the block stalls,
	// and drops valid for random bursts when idling is enabled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			src_gap_left <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				cipher_step(item);
				items_taken++;
			end
			if (!(item_valid && item_stall)) begin
				if (src_gap_left != 0) begin
					item_valid <= 1'b0;
					src_gap_left <= src_gap_left - 1;
				end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
					item_valid <= 1'b0;
					src_gap_left <= $urandom_range(0, 17);
				end else if (items_to_send.size() != 0) begin
					item <= items_to_send.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes results, compares them field by field with the oldest prediction
	// and stalls the block in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			snk_stall_left <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (cipher_results.size() == 0) begin
					$error("unexpected result: char_out %h, status %0d", res.char_out, res.status);
					fail_count++;
				end else begin
					oldest_result = cipher_results.pop_front();
					if (res.char_out !== oldest_result.char_out) begin
						$error("char_out: expected %h, got %h", oldest_result.char_out, res.char_out);
						fail_count++;
					end
					if (res.status !== oldest_result.status) begin
						$error("status: expected %0d, got %0d", oldest_result.status, res.status);
						fail_count++;
					end
				end
			end
			if (snk_stall_left != 0) begin
				res_stall <= 1'b1;
				snk_stall_left <= snk_stall_left - 1;
			end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
				res_stall <= 1'b1;
				snk_stall_left <= $urandom_range(0, 17);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The basic character set: lower-case letters, underscore and digits.
	function automatic logic [CHAR_W-1:0] charset_at(input int unsigned i);
		if (i < 26) begin
			return CHAR_LOWER_A + CHAR_W'(i);
		end else if (i == 26) begin
			return CHAR_UNDERSCORE;
		end
		return "0" + CHAR_W'(i - 27);
	endfunction

	// Mostly characters that hit the active alphabet, in either case and with spaces
	// for underscores, and now and then an unrelated byte.
	function automatic logic [CHAR_W-1:0] pick_char();
		logic [CHAR_W-1:0] c;
		int unsigned       roll;
		roll = $urandom_range(0, 99);
		if (roll < 75 && alphabet_span() != 0) begin
			c = alpha_plan[$urandom_range(0, alphabet_span() - 1)];
		end else if (roll < 90) begin
			c = charset_at($urandom_range(0, CHARSET_LEN - 1));
		end else begin
			c = CHAR_W'($urandom_range(0, 255));
		end
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z && $urandom_range(0, 1)) begin
			c = c - CASE_OFFSET;
		end else if (c == CHAR_UNDERSCORE && $urandom_range(0, 1)) begin
			c = CHAR_SPACE;
		end
		return c;
	endfunction

	task automatic push_item(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
	                         input logic [ENTRY_W-1:0] e);
		items_to_send.push_back('{mode: m, char_in: c, entry_index: e});
		items_queued++;
		if (m == MODE_LOAD) begin
			alpha_plan[e] = c;
		end
		if (m <= MODE_RESTART) begin
			worked_items++;
		end
	endtask

	task automatic push_text(input logic [CHAR_W-1:0] c);
		push_item(MODE_TEXT, c, ENTRY_W'($urandom_range(0, 63)));
	endtask

	task automatic push_key(input logic [CHAR_W-1:0] c);
		push_item(MODE_APPEND, c, ENTRY_W'($urandom_range(0, 63)));
	endtask

	// Clears the key, offers a store's worth of alphabet characters, then two more keys and two texts.
	task automatic push_key_fill();
		push_item(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)), '0);
		for (int i = 0; i < KEY_DEPTH; i++) begin
			push_key(alpha_plan[$urandom_range(0, alphabet_span() - 1)]);
		end
		push_key(alpha_plan[$urandom_range(0, alphabet_span() - 1)]);
		push_key(pick_char());
		push_text(pick_char());
		push_text(pick_char());
	endtask

	// Configuration writes land at once; the shadow follows at the same edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ALPHABET_SIZE) begin
			size_shadow = data[SIZE_W-1:0];
		end else begin
			dir_shadow = data[0];
		end
	endtask

	// Waits until every queued item is taken and every predicted result has come, then
	// lets the block finish any item that produces nothing.
	task automatic drain();
		while (items_taken != items_queued || cipher_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random stimulus for one phase. It opens with text under whatever key the last
	// phase left, so that key indices from a larger alphabet get exercised.
	task automatic gen_phase(input int unsigned quota);
		int unsigned target;
		int unsigned kind;
		int unsigned len;
		target = worked_items + quota;
		for (int i = 0; i < 8; i++) begin
			push_text(pick_char());
		end
		while (worked_items < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				// A well-formed message: often a fresh key, then a run of text.
				if ($urandom_range(0, 99) < 70) begin
					push_item(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)),
					          ENTRY_W'($urandom_range(0, 63)));
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++) begin
						push_key(pick_char());
					end
				end
				len = $urandom_range(4, 24);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 8) begin
						push_item(MODE_RESTART, CHAR_W'($urandom_range(0, 255)),
						          ENTRY_W'($urandom_range(0, 63)));
					end else begin
						push_text(pick_char());
					end
				end
			end else if (kind < 63) begin
				if (alphabet_span() != 0) begin
					push_key_fill();
				end
			end else if (kind < 80) begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 70) begin
						push_item(MODE_LOAD, charset_at($urandom_range(0, CHARSET_LEN - 1)),
						          ENTRY_W'($urandom_range(0, 63)));
					end else begin
						push_item(MODE_LOAD, CHAR_W'($urandom_range(0, 255)),
						          ENTRY_W'($urandom_range(0, 63)));
					end
				end
			end else begin
				// Noise: any mode, any byte, including the spare codes.
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					push_item(MODE_W'($urandom_range(0, 7)), CHAR_W'($urandom_range(0, 255)),
					          ENTRY_W'($urandom_range(0, 63)));
				end
			end
		end
	endtask

	task automatic run_phase(input int unsigned span_cfg, input bit dir_cfg,
	                         input int src_pct, input int snk_pct, input int unsigned quota);
		write_reg(REG_ALPHABET_SIZE, CFG_DATA_W'(span_cfg));
		write_reg(REG_DIRECTION, CFG_DATA_W'(dir_cfg));
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		gen_phase(quota);
		drain();
	endtask

	initial begin
		for (int i = 0; i < ALPHABET_DEPTH; i++) begin
			alpha_shadow[i] = '0;
			alpha_plan[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Every slot is loaded before any search, since unloaded slots read as unknown.
		// Beyond the basic set come a duplicate 'a' (the first match must win), an
		// upper-case letter and a space (neither can ever match), and the byte extremes.
		for (int i = 0; i < ALPHABET_DEPTH; i++) begin
			if (i < CHARSET_LEN) begin
				push_item(MODE_LOAD, charset_at(i), ENTRY_W'(i));
			end else if (i == 37) begin
				push_item(MODE_LOAD, CHAR_LOWER_A, ENTRY_W'(i));
			end else if (i == 38) begin
				push_item(MODE_LOAD, CHAR_UPPER_A, ENTRY_W'(i));
			end else if (i == 39) begin
				push_item(MODE_LOAD, CHAR_SPACE, ENTRY_W'(i));
			end else if (i == 40) begin
				push_item(MODE_LOAD, 8'h00, ENTRY_W'(i));
			end else if (i == 41) begin
				push_item(MODE_LOAD, 8'hFF, ENTRY_W'(i));
			end else begin
				push_item(MODE_LOAD, CHAR_W'($urandom_range(0, 255)), ENTRY_W'(i));
			end
		end

		// Directed items under the reset settings: size 27, encrypt.
		push_text("h");
		for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
			push_item(MODE_W'(m), 8'hFF, '1);
		end
		push_key("K");
		push_key(CHAR_SPACE);
		push_key("#");
		push_key(8'hFF);
		push_key(8'h00);
		push_text("a");
		push_text("Z");
		push_text(CHAR_SPACE);
		push_text(8'h00);
		push_text(8'hFF);
		push_text("9");
		push_text("m");
		push_item(MODE_RESTART, 8'h00, '0);
		push_text("q");
		push_item(MODE_CLEAR, 8'hFF, '1);
		push_text("x");
		push_key("b");
		push_text("y");
		// A full key store answers a matching key character with an error.
		push_key_fill();
		drain();

		// Phases with different sizes and directions, the extremes among them; a size
		// above the depth must behave as the depth, a size of zero matches nothing.
		run_phase(64, 1'b1, 10, 10, 200);
		run_phase(127, 1'b0, 25, 5, 200);
		run_phase(10, 1'b1, 5, 30, 150);
		run_phase(1, 1'b0, 0, 0, 80);
		run_phase(0, 1'b0, 15, 15, 60);
		run_phase(36, 1'b0, 10, 10, 200);
		// The closing stretch runs at full rate on both sides.
		run_phase(64, 1'b1, 0, 0, 150);

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/vcc_pkg.sv
sv/vcc_alpha_ram.sv
sv/vigenere_charset_cipher.sv
tb/tb.sv
